// ----- rtl/srr_pkg.sv -----
// Shared constants, types and helpers for the selective-repeat receiver.
`default_nettype none
package srr_pkg;

   localparam int WINDOW_SLOTS = 8;
   localparam int SEQ_SPACE    = 16;
   localparam int NUM_SENDERS  = 8;
   localparam int PAYLOAD_BITS = 64;

   localparam int ID_BITS     = 3;
   localparam int SEQ_BITS    = 4;
   localparam int TYPE_BITS   = 2;
   localparam int PORT_PAY    = 64;
   localparam int SLOT_BITS   = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
   localparam int SRC_BITS    = (NUM_SENDERS > 1) ? $clog2(NUM_SENDERS) : 1;
   localparam int ADDR_BITS   = SRC_BITS + SLOT_BITS;
   localparam int TOTAL_SLOTS = NUM_SENDERS * WINDOW_SLOTS;
   localparam int ENTRY_BITS  = TYPE_BITS + PAYLOAD_BITS;

   localparam logic RESULT_ACK     = 1'b0;
   localparam logic RESULT_DELIVER = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_ACK  = 3'b010,
      ST_REL  = 3'b100
   } state_type;

   // Advance a sequence number modulo the sequence space.
   function automatic logic [SEQ_BITS-1:0] seq_inc(input logic [SEQ_BITS-1:0] s);
      logic [SEQ_BITS-1:0] r;
      if (int'(s) == SEQ_SPACE - 1) begin
         r = '0;
      end else begin
         r = s + 1'b1;
      end
      return r;
   endfunction

   // Slot of a sequence number within its sender's window.
   function automatic logic [SLOT_BITS-1:0] seq_slot(input logic [SEQ_BITS-1:0] s);
      return SLOT_BITS'(int'(s) % WINDOW_SLOTS);
   endfunction

endpackage
`default_nettype wire

// ----- rtl/srr_slot_ram.sv -----
// Single-port-write, single-port-read slot memory with registered read data.
`default_nettype none
module srr_slot_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 66
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read returns the old contents on a same-address write.
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ----- rtl/selective_repeat_receiver_top.sv -----
// Top level of the selective-repeat receiver with per-sender windows.
// An accepted frame gives its ack in the cycle after acceptance, then one delivery
// per cycle for each of the k frames released (k = 0..8).
// The release walk reads one slot of the slot memory per cycle, which sets the rate.
// Dropped frames give no result and leave the receiver idle. Results cannot be stalled.
// Synchronous reset clears all windows, filled marks and own_id; no clearing pass.
`default_nettype none
module selective_repeat_receiver_top
   import srr_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic                 req_crc_ok,
   input  wire logic [ID_BITS-1:0]   req_dest_id,
   input  wire logic [ID_BITS-1:0]   req_src_id,
   input  wire logic [SEQ_BITS-1:0]  req_seq_num,
   input  wire logic [TYPE_BITS-1:0] req_frag_type,
   input  wire logic [PORT_PAY-1:0]  req_payload,
   output logic                      rsp_strobe,
   output logic                      rsp_result_kind,
   output logic [ID_BITS-1:0]        rsp_peer_id,
   output logic [SEQ_BITS-1:0]       rsp_out_seq,
   output logic [TYPE_BITS-1:0]      rsp_out_type,
   output logic [PORT_PAY-1:0]       rsp_out_payload,
   output logic                      rsp_last,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [ID_BITS-1:0]   csr_own_id
);

   state_type                state_ff, state_in;
   logic [ID_BITS-1:0]       own_id_ff;
   logic [TOTAL_SLOTS-1:0]   filled_ff, filled_in;
   logic [SEQ_BITS-1:0]      exp_ff [NUM_SENDERS];
   logic [SRC_BITS-1:0]      src_ff;
   logic [SEQ_BITS-1:0]      seq_ff;
   logic [TYPE_BITS-1:0]     type_ff;
   logic [PAYLOAD_BITS-1:0]  pay_ff;
   logic [SEQ_BITS-1:0]      cur_ff, cur_in;
   logic                     fwd_ff, fwd_in;

   logic                     accept, keep;
   logic [SEQ_BITS-1:0]      exp_rd, win_off;
   logic                     in_win, store, rel_go, nxt_go;
   logic [SLOT_BITS-1:0]     st_slot, exp_slot, cur_slot, nxt_slot;
   logic [ADDR_BITS-1:0]     st_addr, rd_addr;
   logic [ENTRY_BITS-1:0]    ram_rdata, entry;
   logic                     exp_we;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign keep      = req_crc_ok && (req_dest_id == own_id_ff)
                      && (int'(req_src_id) < NUM_SENDERS);

   // Store decision for the held frame.
   assign exp_rd   = exp_ff[src_ff];
   assign win_off  = seq_ff - exp_rd;
   assign in_win   = (int'(seq_ff) < SEQ_SPACE) && (int'(win_off) < WINDOW_SLOTS);
   assign st_slot  = seq_slot(seq_ff);
   assign st_addr  = {src_ff, st_slot};
   assign store    = (state_ff == ST_ACK) && in_win && !filled_ff[st_addr];
   assign exp_slot = seq_slot(exp_rd);
   assign rel_go   = filled_ff[{src_ff, exp_slot}] || (store && (st_slot == exp_slot));

   // Release walk.
   assign cur_slot = seq_slot(cur_ff);
   assign nxt_slot = seq_slot(seq_inc(cur_ff));
   assign nxt_go   = filled_ff[{src_ff, nxt_slot}] && (nxt_slot != cur_slot);
   assign entry    = fwd_ff ? {type_ff, pay_ff} : ram_rdata;

   always_comb begin
      state_in  = state_ff;
      filled_in = filled_ff;
      cur_in    = cur_ff;
      fwd_in    = 1'b0;
      exp_we    = 1'b0;
      rd_addr   = {src_ff, exp_slot};
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && keep) begin
               state_in = ST_ACK;
            end
         end
         ST_ACK: begin
            if (store) begin
               filled_in[st_addr] = 1'b1;
            end
            cur_in   = exp_rd;
            fwd_in   = store && (st_slot == exp_slot);
            state_in = rel_go ? ST_REL : ST_IDLE;
         end
         ST_REL: begin
            filled_in[{src_ff, cur_slot}] = 1'b0;
            cur_in   = seq_inc(cur_ff);
            exp_we   = 1'b1;
            rd_addr  = {src_ff, nxt_slot};
            state_in = nxt_go ? ST_REL : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_strobe      = 1'b0;
      rsp_result_kind = RESULT_ACK;
      rsp_peer_id     = ID_BITS'(src_ff);
      rsp_out_seq     = seq_ff;
      rsp_out_type    = '0;
      rsp_out_payload = '0;
      rsp_last        = 1'b0;
      unique case (state_ff)
         ST_ACK: begin
            rsp_strobe = 1'b1;
            rsp_last   = !rel_go;
         end
         ST_REL: begin
            rsp_strobe      = 1'b1;
            rsp_result_kind = RESULT_DELIVER;
            rsp_out_seq     = cur_ff;
            rsp_out_type    = entry[ENTRY_BITS-1 -: TYPE_BITS];
            rsp_out_payload = PORT_PAY'(entry[PAYLOAD_BITS-1:0]);
            rsp_last        = !nxt_go;
         end
         default: begin
            rsp_strobe = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         own_id_ff <= '0;
         filled_ff <= '0;
         fwd_ff    <= 1'b0;
         for (int i = 0; i < NUM_SENDERS; i++) begin
            exp_ff[i] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         filled_ff <= filled_in;
         fwd_ff    <= fwd_in;
         if (csr_valid && csr_ready) begin
            own_id_ff <= csr_own_id;
         end
         if (exp_we) begin
            exp_ff[src_ff] <= cur_in;
         end
      end
   end

   // Hold the accepted transaction and the walk position.
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (accept) begin
         src_ff  <= SRC_BITS'(req_src_id);
         seq_ff  <= req_seq_num;
         type_ff <= req_frag_type;
         pay_ff  <= req_payload[PAYLOAD_BITS-1:0];
      end
   end

   srr_slot_ram #(
      .DEPTH(TOTAL_SLOTS),
      .WIDTH(ENTRY_BITS)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (store),
      .wr_addr(st_addr),
      .wr_data({type_ff, pay_ff}),
      .rd_addr(rd_addr),
      .rd_data(ram_rdata)
   );

`ifndef SYNTHESIS
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result outside a transaction");

   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |=> (rsp_strobe && rsp_result_kind == RESULT_DELIVER))
      else $error("delivery missing after non-final result");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |=> !busy)
      else $error("still busy after final result");

   a_deliver_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_result_kind == RESULT_DELIVER) |-> $past(rsp_strobe))
      else $error("delivery without preceding result");
`endif

endmodule
`default_nettype wire
